### rtl/tfhd_pkg.sv
// Package for the text frame header decoder: shared constants, the
// configuration register indexes and the configuration bundle type.
// No dependencies; every other file of the block imports it.
package tfhd_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int FIELD_INDEX_WIDTH = 3;

   // Default number of magic characters.
   localparam int MAGIC_LENGTH_DEFAULT = 4;

   // Number of fields in a well-formed header.
   localparam logic [FIELD_INDEX_WIDTH-1:0] FIELD_COUNT = 3'd4;

   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] COUNT_MAX    = 8'hFF;

   localparam logic [DATA_WIDTH-1:0] MAGIC_WORD_RESET         = 32'h5A4E_5632;
   localparam logic [BYTE_WIDTH-1:0] MAX_HEADER_LENGTH_RESET  = 8'd64;
   localparam logic [DATA_WIDTH-1:0] MAX_PAYLOAD_LENGTH_RESET = 32'd65536;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAGIC_WORD         = 2'd0,
      CSR_MAX_HEADER_LENGTH  = 2'd1,
      CSR_MAX_PAYLOAD_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] magic_word;
      logic [BYTE_WIDTH-1:0] max_header_length;
      logic [DATA_WIDTH-1:0] max_payload_length;
   } cfg_type;

endpackage

### rtl/tfhd_if.sv
// Channel interfaces of the text frame header decoder: header bytes in,
// decoded headers out, and the register write channel.
// Depends on tfhd_pkg.
interface tfhd_req_if import tfhd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] header_byte;
   logic                  final_byte;

   modport source (output valid, output header_byte, output final_byte, input ready);
   modport sink   (input valid, input header_byte, input final_byte, output ready);
endinterface

interface tfhd_rsp_if import tfhd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  invalid;
   logic [DATA_WIDTH-1:0] header_id;
   logic [DATA_WIDTH-1:0] opcode_value;
   logic [DATA_WIDTH-1:0] body_length;

   modport source (output valid, output invalid, output header_id, output opcode_value,
                   output body_length, input ready);
   modport sink   (input valid, input invalid, input header_id, input opcode_value,
                   input body_length, output ready);
endinterface

interface tfhd_csr_if import tfhd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tfhd_csr.sv
// Configuration registers of the text frame header decoder.
// Depends on tfhd_pkg and tfhd_csr_if; a write takes effect on the next cycle.
module tfhd_csr import tfhd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tfhd_csr_if.sink   csr_bus,
   output cfg_type    cfg
);

   logic [DATA_WIDTH-1:0] magic_word_ff, magic_word_in;
   logic [BYTE_WIDTH-1:0] max_header_length_ff, max_header_length_in;
   logic [DATA_WIDTH-1:0] max_payload_length_ff, max_payload_length_in;

   // Writes never stall.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      magic_word_in         = magic_word_ff;
      max_header_length_in  = max_header_length_ff;
      max_payload_length_in = max_payload_length_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MAGIC_WORD: begin
               magic_word_in = csr_bus.data;
            end
            CSR_MAX_HEADER_LENGTH: begin
               max_header_length_in = csr_bus.data[BYTE_WIDTH-1:0];
            end
            CSR_MAX_PAYLOAD_LENGTH: begin
               max_payload_length_in = csr_bus.data;
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff         <= MAGIC_WORD_RESET;
         max_header_length_ff  <= MAX_HEADER_LENGTH_RESET;
         max_payload_length_ff <= MAX_PAYLOAD_LENGTH_RESET;
      end else begin
         magic_word_ff         <= magic_word_in;
         max_header_length_ff  <= max_header_length_in;
         max_payload_length_ff <= max_payload_length_in;
      end
   end

   assign cfg.magic_word         = magic_word_ff;
   assign cfg.max_header_length  = max_header_length_ff;
   assign cfg.max_payload_length = max_payload_length_ff;

endmodule

### rtl/text_frame_header_decoder_unit.sv
// Text frame header decoder, top level: byte parser, input and result registers.
// Depends on tfhd_pkg, tfhd_if.sv and tfhd_csr.
//
// The decoder takes a text frame header of the form "MAGIC id opcode length"
// followed by a newline, one byte per req_bus transaction, and on the byte
// marked final_byte it delivers one rsp_bus transaction carrying the request
// id, opcode and payload length, together with a single invalid flag that
// covers every kind of failure: wrong magic, a field count other than four,
// an empty field, a non-canonical or overflowing decimal, a zero id or
// opcode, a length above max_payload_length, a header longer than
// max_header_length bytes, or a last byte that is not a newline. When
// invalid is set the three numeric fields read as zero. Bytes that are not
// marked final produce no result. One byte is accepted every clock cycle
// unless the input side stalls; a byte passes through the input register,
// and the result of a final byte is loaded from there into the result
// register, which drives rsp_bus.valid. The only loop is the parse state
// itself, which is updated from the input register by one compare chain
// and a 36-bit multiply-by-ten-and-add built from shifts. The input side
// stalls only when a final byte waits for a result register that is still
// held by the sink. Configuration registers are written through csr_bus,
// which never stalls, and must only be changed while no header is in
// progress.
module text_frame_header_decoder_unit import tfhd_pkg::*; #(
   parameter int MAGIC_LENGTH = MAGIC_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tfhd_req_if.sink   req_bus,
   tfhd_rsp_if.source rsp_bus,
   tfhd_csr_if.sink   csr_bus
);

   localparam int MAGIC_POS_WIDTH = (MAGIC_LENGTH > 1) ? $clog2(MAGIC_LENGTH) : 1;
   localparam int MAGIC_SLOTS     = 2 ** MAGIC_POS_WIDTH;
   localparam int EXT_WIDTH       = 64;
   localparam int PROD_WIDTH      = DATA_WIDTH + 4;

   cfg_type cfg;

   tfhd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Input register.
   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_WIDTH-1:0] s1_byte_ff;
   logic                  s1_final_ff;
   logic                  s1_fire;
   logic                  req_fire;

   // Parse state.
   logic [FIELD_INDEX_WIDTH-1:0] field_index_ff, field_index_in;
   logic [BYTE_WIDTH-1:0]        field_count_ff, field_count_in;
   logic [BYTE_WIDTH-1:0]        total_count_ff, total_count_in;
   logic                         magic_match_ff, magic_match_in;
   logic [DATA_WIDTH-1:0]        accum_ff, accum_in;
   logic                         lead_zero_ff, lead_zero_in;
   logic                         error_ff, error_in;
   logic [DATA_WIDTH-1:0]        saved_id_ff, saved_id_in;
   logic [DATA_WIDTH-1:0]        saved_opcode_ff, saved_opcode_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_invalid_ff, out_invalid_in;
   logic [DATA_WIDTH-1:0] out_id_ff, out_id_in;
   logic [DATA_WIDTH-1:0] out_opcode_ff, out_opcode_in;
   logic [DATA_WIDTH-1:0] out_length_ff, out_length_in;
   logic                  out_load;

   // Parser intermediates.
   logic                    is_sep;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [PROD_WIDTH-1:0]   accum_next;
   logic                    overflow;
   logic [BYTE_WIDTH-1:0]   total_inc;
   logic [EXT_WIDTH-1:0]    magic_ext;
   logic [BYTE_WIDTH-1:0]   magic_chars [MAGIC_SLOTS];
   logic [BYTE_WIDTH-1:0]   expected_char;
   logic                    bad;

   // The input register drains every cycle unless it holds a final byte
   // while the result register is occupied and not being taken.
   assign s1_fire  = s1_valid_ff && (!s1_final_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_load = s1_fire && s1_final_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Magic characters, first one in the most significant used byte; bytes
   // above the 32-bit register read as zero.
   assign magic_ext = {{(EXT_WIDTH - DATA_WIDTH){1'b0}}, cfg.magic_word};

   for (genvar k = 0; k < MAGIC_SLOTS; k++) begin : g_magic
      if (k < MAGIC_LENGTH) begin : g_used
         assign magic_chars[k] = magic_ext[BYTE_WIDTH*(MAGIC_LENGTH-1-k) +: BYTE_WIDTH];
      end else begin : g_spare
         assign magic_chars[k] = '0;
      end
   end

   assign expected_char = magic_chars[field_count_ff[MAGIC_POS_WIDTH-1:0]];

   assign is_sep   = (s1_byte_ff == CHAR_SPACE) || (s1_byte_ff == CHAR_NEWLINE);
   assign is_digit = (s1_byte_ff >= CHAR_ZERO) && (s1_byte_ff <= CHAR_NINE);
   assign digit    = s1_byte_ff[3:0];

   // accum * 10 + digit, wide enough that any carry past 32 bits shows overflow.
   assign accum_next = ({{(PROD_WIDTH - DATA_WIDTH){1'b0}}, accum_ff} << 3)
                     + ({{(PROD_WIDTH - DATA_WIDTH){1'b0}}, accum_ff} << 1)
                     + PROD_WIDTH'(digit);
   assign overflow   = |accum_next[PROD_WIDTH-1:DATA_WIDTH];

   assign total_inc = (total_count_ff != COUNT_MAX) ? total_count_ff + 8'd1 : total_count_ff;

   always_comb begin
      field_index_in  = field_index_ff;
      field_count_in  = field_count_ff;
      total_count_in  = total_count_ff;
      magic_match_in  = magic_match_ff;
      accum_in        = accum_ff;
      lead_zero_in    = lead_zero_ff;
      error_in        = error_ff;
      saved_id_in     = saved_id_ff;
      saved_opcode_in = saved_opcode_ff;
      out_invalid_in  = out_invalid_ff;
      out_id_in       = out_id_ff;
      out_opcode_in   = out_opcode_ff;
      out_length_in   = out_length_ff;
      bad             = 1'b0;

      if (s1_fire) begin
         total_count_in = total_inc;
         if (total_inc > cfg.max_header_length) begin
            error_in = 1'b1;
         end

         if (is_sep) begin
            if ((field_index_ff >= FIELD_COUNT) || (field_count_ff == '0)) begin
               error_in = 1'b1;
            end else begin
               case (field_index_ff)
                  3'd0: begin
                     if ((field_count_ff != BYTE_WIDTH'(MAGIC_LENGTH)) || !magic_match_ff) begin
                        error_in = 1'b1;
                     end
                  end
                  3'd1: begin
                     if (accum_ff == '0) begin
                        error_in = 1'b1;
                     end
                     saved_id_in = accum_ff;
                  end
                  3'd2: begin
                     if (accum_ff == '0) begin
                        error_in = 1'b1;
                     end
                     saved_opcode_in = accum_ff;
                  end
                  default: begin
                     if (accum_ff > cfg.max_payload_length) begin
                        error_in = 1'b1;
                     end
                  end
               endcase
               field_index_in = field_index_ff + 3'd1;
            end
            field_count_in = '0;
            accum_in       = '0;
            lead_zero_in   = 1'b0;
            magic_match_in = 1'b1;
         end else begin
            if (field_index_ff == '0) begin
               if ((field_count_ff >= BYTE_WIDTH'(MAGIC_LENGTH)) ||
                   (expected_char != s1_byte_ff)) begin
                  magic_match_in = 1'b0;
               end
            end else if (field_index_ff < FIELD_COUNT) begin
               if (!is_digit) begin
                  error_in = 1'b1;
               end else begin
                  if (lead_zero_ff) begin
                     error_in = 1'b1;
                  end
                  if ((field_count_ff == '0) && (digit == 4'd0)) begin
                     lead_zero_in = 1'b1;
                  end
                  if (overflow) begin
                     error_in = 1'b1;
                  end else begin
                     accum_in = accum_next[DATA_WIDTH-1:0];
                  end
               end
            end else begin
               error_in = 1'b1;
            end
            if (field_count_ff != COUNT_MAX) begin
               field_count_in = field_count_ff + 8'd1;
            end
         end

         if (s1_final_ff) begin
            // A good header ends with the newline that closes the length
            // field, so the length is the accumulator before this byte.
            bad = error_in || (s1_byte_ff != CHAR_NEWLINE) || (field_index_in != FIELD_COUNT);
            out_invalid_in  = bad;
            out_id_in       = bad ? '0 : saved_id_in;
            out_opcode_in   = bad ? '0 : saved_opcode_in;
            out_length_in   = bad ? '0 : accum_ff;
            field_index_in  = '0;
            field_count_in  = '0;
            total_count_in  = '0;
            magic_match_in  = 1'b1;
            accum_in        = '0;
            lead_zero_in    = 1'b0;
            error_in        = 1'b0;
            saved_id_in     = '0;
            saved_opcode_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         field_index_ff  <= '0;
         field_count_ff  <= '0;
         total_count_ff  <= '0;
         magic_match_ff  <= 1'b1;
         accum_ff        <= '0;
         lead_zero_ff    <= 1'b0;
         error_ff        <= 1'b0;
         saved_id_ff     <= '0;
         saved_opcode_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
         field_index_ff  <= field_index_in;
         field_count_ff  <= field_count_in;
         total_count_ff  <= total_count_in;
         magic_match_ff  <= magic_match_in;
         accum_ff        <= accum_in;
         lead_zero_ff    <= lead_zero_in;
         error_ff        <= error_in;
         saved_id_ff     <= saved_id_in;
         saved_opcode_ff <= saved_opcode_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_bus.header_byte;
         s1_final_ff <= req_bus.final_byte;
      end
      out_invalid_ff <= out_invalid_in;
      out_id_ff      <= out_id_in;
      out_opcode_ff  <= out_opcode_in;
      out_length_ff  <= out_length_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.invalid      = out_invalid_ff;
   assign rsp_bus.header_id    = out_id_ff;
   assign rsp_bus.opcode_value = out_opcode_ff;
   assign rsp_bus.body_length  = out_length_ff;

`ifndef SYNTH
   // The field index never runs past the field count.
   a_field_index_range: assert property (@(posedge clock) disable iff (reset)
      field_index_ff <= FIELD_COUNT)
      else $error("field index beyond field count");

   // A final byte leaves the parser in its cleared state.
   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_final_ff) |=> (field_index_ff == '0 && total_count_ff == '0 &&
                                    !error_ff && magic_match_ff))
      else $error("parse state not cleared after final byte");

   // A final byte must not overwrite a result that the sink has not taken.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !out_load)
      else $error("result register overwritten");

   // An accepted header always has a nonzero id and opcode.
   a_good_fields_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_invalid_ff) |-> (out_id_ff != '0 && out_opcode_ff != '0))
      else $error("accepted header with zero id or opcode");

   // A rejected header reports all numeric fields as zero.
   a_bad_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_invalid_ff) |->
         (out_id_ff == '0 && out_opcode_ff == '0 && out_length_ff == '0))
      else $error("rejected header with nonzero fields");
`endif

endmodule

### test/tfhd_decode_checker.sv
`timescale 1ns / 100ps
// Checker for the text frame header decoder: watches the byte, result and
// register channels, predicts every decoded header and compares it.
// Depends on tfhd_pkg and the channel interfaces in tfhd_if.sv.
module tfhd_decode_checker import tfhd_pkg::*; #(
   parameter int MAGIC_LENGTH = MAGIC_LENGTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tfhd_req_if  req_bus,
   tfhd_rsp_if  rsp_bus,
   tfhd_csr_if  csr_bus,
   output int   mismatch_count,
   output int   outstanding,
   output int   decoded_count,
   output int   accepted_count
);

   typedef struct packed {
      logic                  invalid;
      logic [DATA_WIDTH-1:0] header_id;
      logic [DATA_WIDTH-1:0] opcode_value;
      logic [DATA_WIDTH-1:0] body_length;
   } decoded_header_type;

   cfg_type                      cfg;
   logic [FIELD_INDEX_WIDTH-1:0] field_index;
   logic [BYTE_WIDTH-1:0]        field_len;
   logic [BYTE_WIDTH-1:0]        header_len;
   logic                         magic_ok;
   logic [DATA_WIDTH-1:0]        number_acc;
   logic                         zero_lead;
   logic                         error_flag;
   logic [DATA_WIDTH-1:0]        id_seen;
   logic [DATA_WIDTH-1:0]        opcode_seen;
   decoded_header_type           expected_headers[$];

   function automatic void clear_parse_state();
      field_index = '0;
      field_len   = '0;
      header_len  = '0;
      magic_ok    = 1'b1;
      number_acc  = '0;
      zero_lead   = 1'b0;
      error_flag  = 1'b0;
      id_seen     = '0;
      opcode_seen = '0;
   endfunction

   // Advances the parse by one byte; returns 1 with the decoded header when
   // the byte closes the header.
   function automatic bit decode_header_byte(input logic [BYTE_WIDTH-1:0] b,
                                             input logic fin,
                                             output decoded_header_type hdr);
      logic [DATA_WIDTH-1:0] payload;
      logic [DATA_WIDTH-1:0] digit;
      logic [63:0]           word;
      logic                  bad;
      payload = '0;
      hdr     = '0;
      if (header_len != COUNT_MAX) header_len++;
      if (header_len > cfg.max_header_length) error_flag = 1'b1;

      if (b == CHAR_SPACE || b == CHAR_NEWLINE) begin
         if (field_index >= FIELD_COUNT || field_len == 0) begin
            error_flag = 1'b1;
         end else begin
            case (field_index)
               3'd0: if (field_len != MAGIC_LENGTH || !magic_ok) error_flag = 1'b1;
               3'd1: begin
                  if (number_acc == 0) error_flag = 1'b1;
                  id_seen = number_acc;
               end
               3'd2: begin
                  if (number_acc == 0) error_flag = 1'b1;
                  opcode_seen = number_acc;
               end
               default: begin
                  if (number_acc > cfg.max_payload_length) error_flag = 1'b1;
                  payload = number_acc;
               end
            endcase
            field_index++;
         end
         field_len  = '0;
         number_acc = '0;
         zero_lead  = 1'b0;
         magic_ok   = 1'b1;
      end else begin
         if (field_index == 0) begin
            word = {32'd0, cfg.magic_word};
            if (field_len >= MAGIC_LENGTH)
               magic_ok = 1'b0;
            else if (8'(word >> (8 * (MAGIC_LENGTH - 1 - int'(field_len)))) != b)
               magic_ok = 1'b0;
         end else if (field_index < FIELD_COUNT) begin
            if (b < CHAR_ZERO || b > CHAR_NINE) begin
               error_flag = 1'b1;
            end else begin
               digit = 32'(b - CHAR_ZERO);
               if (zero_lead) error_flag = 1'b1;
               if (field_len == 0 && digit == 0) zero_lead = 1'b1;
               if (number_acc > (32'hFFFF_FFFF - digit) / 32'd10)
                  error_flag = 1'b1;
               else
                  number_acc = number_acc * 32'd10 + digit;
            end
         end else begin
            error_flag = 1'b1;
         end
         if (field_len != COUNT_MAX) field_len++;
      end

      if (!fin) return 1'b0;
      bad = error_flag || b != CHAR_NEWLINE || field_index != FIELD_COUNT;
      hdr.invalid = bad;
      if (!bad) begin
         hdr.header_id    = id_seen;
         hdr.opcode_value = opcode_seen;
         hdr.body_length  = payload;
      end
      clear_parse_state();
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      decoded_header_type predicted;
      decoded_header_type observed;
      if (reset) begin
         cfg.magic_word         = MAGIC_WORD_RESET;
         cfg.max_header_length  = MAX_HEADER_LENGTH_RESET;
         cfg.max_payload_length = MAX_PAYLOAD_LENGTH_RESET;
         clear_parse_state();
         expected_headers.delete();
         mismatch_count <= 0;
         outstanding    <= 0;
         decoded_count  <= 0;
         accepted_count <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_MAGIC_WORD:         cfg.magic_word = csr_bus.data;
               CSR_MAX_HEADER_LENGTH:  cfg.max_header_length = csr_bus.data[BYTE_WIDTH-1:0];
               CSR_MAX_PAYLOAD_LENGTH: cfg.max_payload_length = csr_bus.data;
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            if (decode_header_byte(req_bus.header_byte, req_bus.final_byte, predicted))
               expected_headers.push_back(predicted);
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            observed.invalid      = rsp_bus.invalid;
            observed.header_id    = rsp_bus.header_id;
            observed.opcode_value = rsp_bus.opcode_value;
            observed.body_length  = rsp_bus.body_length;
            decoded_count <= decoded_count + 1;
            if (!observed.invalid) accepted_count <= accepted_count + 1;
            if (expected_headers.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%t: unexpected result invalid=%b id=%h opcode=%h length=%h",
                           $realtime, observed.invalid, observed.header_id,
                           observed.opcode_value, observed.body_length);
               mismatch_count <= mismatch_count + 1;
            end else begin
               predicted = expected_headers.pop_front();
               if (observed !== predicted) begin
                  if (mismatch_count < 10)
                     $display({"%t: mismatch invalid exp %b got %b, id exp %h got %h, ",
                               "opcode exp %h got %h, length exp %h got %h"},
                              $realtime, predicted.invalid, observed.invalid,
                              predicted.header_id, observed.header_id,
                              predicted.opcode_value, observed.opcode_value,
                              predicted.body_length, observed.body_length);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         outstanding <= expected_headers.size();
      end
   end

endmodule

### test/tb_text_frame_header_decoder_unit.sv
`timescale 1ns / 100ps
// Top of the text frame header decoder testbench: clock, reset, header
// stimulus, result back-pressure and the final verdict.
// Depends on tfhd_pkg, tfhd_if.sv, the decoder RTL and tfhd_decode_checker.
module tb_text_frame_header_decoder_unit;
   import tfhd_pkg::*;

   // Length of the deliberate long receiver hold-off, in clock cycles.
   localparam int LONG_HOLD_CYCLES = 400;
   // Approximate number of header bytes sent in each random phase.
   localparam int PHASE_BYTES = 95;
   localparam int PHASE_COUNT = 8;

   // Ways in which a generated header is spoilt. FLAW_NONE gives a
   // well-formed header; FLAW_COUNT only marks the end of the list.
   typedef enum int {
      FLAW_NONE, FLAW_MAGIC_CHAR, FLAW_MAGIC_SHORT, FLAW_MAGIC_LONG,
      FLAW_EMPTY_FIELD, FLAW_LEADING_SEP, FLAW_EXTRA_FIELD, FLAW_MISSING_FIELD,
      FLAW_BAD_DIGIT, FLAW_ZERO_ID, FLAW_ZERO_OPCODE, FLAW_LEADING_ZERO,
      FLAW_OVERFLOW, FLAW_LENGTH_HIGH, FLAW_NO_NEWLINE, FLAW_TRUNCATED,
      FLAW_TRAILING, FLAW_COUNT
   } frame_flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfhd_req_if req_bus ();
   tfhd_rsp_if rsp_bus ();
   tfhd_csr_if csr_bus ();

   int mismatch_count;
   int outstanding;
   int decoded_count;
   int accepted_count;

   // Idling control: percentages of cycles in which the sender idles and
   // the receiver stalls. A long hold-off is requested by bumping
   // hold_requests; the receiver process counts it out and bumps holds_done.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_done    = 0;

   int sent_bytes  = 0;
   int sent_frames = 0;

   // Our own copy of the magic word and payload limit, needed to build headers
   // that the decoder should accept under the current setting.
   logic [DATA_WIDTH-1:0] cur_magic       = MAGIC_WORD_RESET;
   logic [DATA_WIDTH-1:0] cur_max_payload = MAX_PAYLOAD_LENGTH_RESET;

   // The header currently being assembled; its last byte carries the final mark.
   logic [BYTE_WIDTH-1:0] frame_text[$];

   text_frame_header_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tfhd_decode_checker decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .decoded_count  (decoded_count),
      .accepted_count (accepted_count)
   );

   always #5 clock = ~clock;

   // Receiver. Outside a hold-off, ready is redrawn every cycle against the
   // stall percentage. A hold-off keeps ready low while the sender carries
   // on, so that the result register fills and the decoder has to stall its
   // byte input.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
            holds_done++;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Offers one byte and returns at the clock edge on which the transaction
   // completes. Ready is read straight after the edge, so it still holds the
   // value that the decoder presented at that edge.
   task automatic push_byte(input logic [BYTE_WIDTH-1:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.header_byte <= b;
      req_bus.final_byte  <= fin;
      do @(posedge clock); while (!req_bus.ready);
      sent_bytes++;
   endtask

   task automatic send_frame();
      foreach (frame_text[i]) push_byte(frame_text[i], i == frame_text.size() - 1);
      sent_frames++;
   endtask

   // Stops offering bytes and waits until every predicted header has been
   // returned, then lets the pipeline settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves valid high; the caller lowers it after its last write.
   task automatic write_reg(input csr_index_type idx, input logic [DATA_WIDTH-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_MAGIC_WORD:         cur_magic = value;
         CSR_MAX_PAYLOAD_LENGTH: cur_max_payload = value;
         default: ;
      endcase
   endtask

   function automatic void put_separator();
      frame_text.push_back(($urandom_range(0, 6) == 0) ? CHAR_NEWLINE : CHAR_SPACE);
   endfunction

   // Appends a decimal number, optionally with one superfluous leading zero.
   function automatic void put_decimal(input logic [63:0] value, input bit extra_zero);
      logic [BYTE_WIDTH-1:0] digits[$];
      if (extra_zero) frame_text.push_back(CHAR_ZERO);
      if (value == 0) digits.push_back(CHAR_ZERO);
      while (value != 0) begin
         digits.push_front(8'(CHAR_ZERO + value % 10));
         value = value / 10;
      end
      foreach (digits[i]) frame_text.push_back(digits[i]);
   endfunction

   // Nonzero identifiers and opcodes, mostly short so that headers stay
   // brief and results come often, with the 32-bit extreme included.
   function automatic logic [63:0] pick_count();
      case ($urandom_range(0, 5))
         0:       return 64'($urandom_range(1, 9));
         1:       return 64'($urandom_range(10, 9999));
         2:       return 64'($urandom_range(1, 32'hFFFF_FFFF));
         3:       return 64'h0000_0000_FFFF_FFFF;
         4:       return 64'($urandom_range(1, 99));
         default: return 64'($urandom_range(1, 1000000));
      endcase
   endfunction

   function automatic logic [63:0] pick_length();
      case ($urandom_range(0, 3))
         0:       return 64'd0;
         1:       return 64'(cur_max_payload);
         2:       return 64'($urandom_range(0, cur_max_payload));
         default: return 64'($urandom_range(0, (cur_max_payload < 999) ? cur_max_payload : 999));
      endcase
   endfunction

   // Builds "magic id opcode length" with a newline, then spoils it as the
   // flaw asks. Separators are mostly spaces with the odd inner newline.
   function automatic void compose_frame(input frame_flaw_type flaw, input logic [63:0] id_val,
                                         input logic [63:0] op_val, input logic [63:0] len_val);
      int                    magic_chars;
      int                    bad_pos;
      int                    empty_at;
      int                    zero_field;
      int                    pos;
      logic [BYTE_WIDTH-1:0] ch;
      frame_text.delete();
      magic_chars = MAGIC_LENGTH_DEFAULT;
      bad_pos     = $urandom_range(0, MAGIC_LENGTH_DEFAULT - 1);
      empty_at    = (flaw == FLAW_EMPTY_FIELD) ? $urandom_range(0, 2) : -1;
      zero_field  = (flaw == FLAW_LEADING_ZERO) ? $urandom_range(1, 3) : 0;
      if (flaw == FLAW_ZERO_ID) id_val = 0;
      if (flaw == FLAW_ZERO_OPCODE) op_val = 0;
      if (flaw == FLAW_LENGTH_HIGH) len_val = 64'(cur_max_payload) + 1;
      if (flaw == FLAW_OVERFLOW) begin
         case ($urandom_range(0, 2))
            0:       id_val  = 64'h1_0000_0000 + $urandom_range(0, 5);
            1:       op_val  = {$urandom, $urandom} | 64'h1_0000_0000;
            default: len_val = 64'h1_0000_0000 + $urandom_range(0, 5);
         endcase
      end
      if (flaw == FLAW_MAGIC_SHORT) magic_chars = $urandom_range(0, MAGIC_LENGTH_DEFAULT - 1);
      if (flaw == FLAW_MAGIC_LONG) magic_chars = $urandom_range(MAGIC_LENGTH_DEFAULT + 1, 8);

      if (flaw == FLAW_LEADING_SEP) put_separator();
      for (int i = 0; i < magic_chars; i++) begin
         if (i < MAGIC_LENGTH_DEFAULT)
            ch = cur_magic[8 * (MAGIC_LENGTH_DEFAULT - 1 - i) +: 8];
         else
            ch = 8'($urandom_range(33, 126));
         if (flaw == FLAW_MAGIC_CHAR && i == bad_pos) ch = ch ^ 8'($urandom_range(1, 255));
         frame_text.push_back(ch);
      end
      put_separator();
      if (empty_at == 0) put_separator();
      put_decimal(id_val, zero_field == 1);
      put_separator();
      if (empty_at == 1) put_separator();
      put_decimal(op_val, zero_field == 2);
      if (flaw != FLAW_MISSING_FIELD) begin
         put_separator();
         if (empty_at == 2) put_separator();
         put_decimal(len_val, zero_field == 3);
      end
      if (flaw == FLAW_EXTRA_FIELD) begin
         put_separator();
         put_decimal(pick_count(), 1'b0);
      end

      // A header may also end on a space or straight after its last digit.
      if (flaw == FLAW_NO_NEWLINE) begin
         if ($urandom_range(0, 1) == 0) frame_text.push_back(CHAR_SPACE);
      end else begin
         frame_text.push_back(CHAR_NEWLINE);
      end
      if (flaw == FLAW_TRAILING) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0:       frame_text.push_back(CHAR_SPACE);
               1:       frame_text.push_back(CHAR_NEWLINE);
               default: frame_text.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      if (flaw == FLAW_BAD_DIGIT) begin
         pos = $urandom_range(magic_chars + 1, frame_text.size() - 2);
         ch  = 8'($urandom_range(0, 255));
         while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_SPACE || ch == CHAR_NEWLINE)
            ch = 8'($urandom_range(0, 255));
         frame_text[pos] = ch;
      end
      if (flaw == FLAW_TRUNCATED) begin
         pos = $urandom_range(1, frame_text.size() - 1);
         while (frame_text.size() > pos) void'(frame_text.pop_back());
      end
   endfunction

   // Short runs of arbitrary bytes, half of them drawn from the characters
   // the parser cares about so that they reach past the magic field.
   function automatic void compose_noise();
      frame_text.delete();
      repeat ($urandom_range(1, 24)) begin
         if ($urandom_range(0, 1) == 0) begin
            frame_text.push_back(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0:       frame_text.push_back(CHAR_SPACE);
               1:       frame_text.push_back(CHAR_NEWLINE);
               2:       frame_text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
               default: frame_text.push_back(cur_magic[8 * $urandom_range(0, 3) +: 8]);
            endcase
         end
      end
   endfunction

   // A header of more than 255 bytes, which drives both byte counters into
   // saturation and can never be accepted.
   function automatic void compose_long_frame();
      frame_text.delete();
      repeat ($urandom_range(256, 300)) frame_text.push_back(cur_magic[31:24]);
      frame_text.push_back(CHAR_NEWLINE);
   endfunction

   // Register settings of the random phases, the extremes among them. Phase
   // zero runs on the values left by reset.
   task automatic apply_setting(input int phase);
      logic [DATA_WIDTH-1:0] magic;
      logic [BYTE_WIDTH-1:0] max_header;
      logic [DATA_WIDTH-1:0] max_payload;
      case (phase)
         1: begin magic = 32'h4142_4344; max_header = 8'd255; max_payload = 32'hFFFF_FFFF; end
         2: begin magic = 32'h0000_0000; max_header = 8'd1;   max_payload = 32'd0;         end
         3: begin magic = 32'hFFFF_FFFF; max_header = 8'd20;  max_payload = 32'd100;       end
         4: begin
            magic = {8'($urandom_range(33, 126)), 8'($urandom_range(33, 126)),
                     8'($urandom_range(33, 126)), 8'($urandom_range(33, 126))};
            max_header  = 8'd40;
            max_payload = $urandom;
         end
         5: begin magic = 32'h2A2D_2B3F; max_header = 8'd255; max_payload = 32'd0; end
         6: begin
            magic       = MAGIC_WORD_RESET;
            max_header  = MAX_HEADER_LENGTH_RESET;
            max_payload = MAX_PAYLOAD_LENGTH_RESET;
         end
         default: begin
            magic       = $urandom;
            max_header  = 8'($urandom_range(24, 255));
            max_payload = $urandom_range(0, 5000);
         end
      endcase
      write_reg(CSR_MAGIC_WORD, magic);
      write_reg(CSR_MAX_HEADER_LENGTH, 32'(max_header));
      write_reg(CSR_MAX_PAYLOAD_LENGTH, max_payload);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stimulus: a directed pass under the reset setting, then eight random
   // phases that step through register settings and idling patterns. Each
   // phase ends with a full drain, which also serves as the sender's pause
   // until every expected header has come back.
   initial begin
      int target;
      int pick;
      req_bus.valid       <= 1'b0;
      req_bus.header_byte <= '0;
      req_bus.final_byte  <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_MAGIC_WORD;
      csr_bus.data        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed part: every flaw once with extreme opcode and length, a good
      // header with extreme id, a newline-only header, and an oversized one.
      for (int f = 0; f < FLAW_COUNT; f++) begin
         compose_frame(frame_flaw_type'(f), 64'(f + 1), 64'h0000_0000_FFFF_FFFF,
                       64'(MAX_PAYLOAD_LENGTH_RESET));
         send_frame();
      end
      compose_frame(FLAW_NONE, 64'h0000_0000_FFFF_FFFF, 64'd1, 64'd0);
      send_frame();
      frame_text.delete();
      frame_text.push_back(CHAR_NEWLINE);
      send_frame();
      compose_long_frame();
      send_frame();
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) apply_setting(phase);
         case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 81; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         // The long hold-off falls in phases where the sender never idles.
         if (phase % 4 == 0) hold_requests++;
         target = sent_bytes + PHASE_BYTES;
         while (sent_bytes < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               compose_frame(FLAW_NONE, pick_count(), pick_count(), pick_length());
            else if (pick < 88)
               compose_frame(frame_flaw_type'($urandom_range(1, FLAW_COUNT - 1)),
                             pick_count(), pick_count(), pick_length());
            else if (pick < 99)
               compose_noise();
            else
               compose_long_frame();
            send_frame();
         end
         drain();
      end

      $display("Run covered %0d header bytes in %0d frames over %0d register settings,",
               sent_bytes, sent_frames, PHASE_COUNT);
      $display("four idling patterns and two long result hold-offs; %0d accepted, %0d rejected.",
               accepted_count, decoded_count - accepted_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("text_frame_header_decoder_unit verification clean");
      end else begin
         $display("text_frame_header_decoder_unit verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of the stimulus above.
   initial begin
      #5_000_000;
      $display("text_frame_header_decoder_unit verification failed");
      $finish;
   end

endmodule

### text_frame_header_decoder_unit.f
rtl/tfhd_pkg.sv
rtl/tfhd_if.sv
rtl/tfhd_csr.sv
rtl/text_frame_header_decoder_unit.sv
test/tfhd_decode_checker.sv
test/tb_text_frame_header_decoder_unit.sv
